FILE: src/assert_macros.svh
// Shared assertion macros. Each expects clk_i and rst_ni in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define TPC_NEVER(label, cond, msg) \
  `TPC_ASSERT(label, !(cond), msg)

`endif

FILE: src/tpc_pkg.sv
package tpc_pkg;

  // Port and field widths
  localparam int TPC_KEY_W      = 32;
  localparam int TPC_COUNT_W    = 16;
  localparam int TPC_CFG_DATA_W = 16;
  localparam int TPC_CFG_IDX_W  = 1;
  localparam int TPC_VOL_W      = 4;

  // Default sizing
  localparam int TPC_MAX_ENTRIES = 8;
  localparam int TPC_KEY_BITS    = 32;

  // Register reset values
  localparam logic [TPC_COUNT_W-1:0] TPC_THR_RESET = 16'd3;
  localparam logic [TPC_VOL_W-1:0]   TPC_VOL_RESET = 4'd4;

  localparam logic [TPC_COUNT_W-1:0] TPC_COUNT_MAX = 16'hFFFF;
  localparam logic [TPC_COUNT_W-1:0] TPC_COUNT_ONE = 16'd1;

  typedef enum logic [TPC_CFG_IDX_W-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_VOLUME    = 1'b1
  } tpc_cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SH_RD,
    ST_SH_WR,
    ST_HEAD,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } tpc_state_e;

endpackage

FILE: src/tpc_if.sv
interface tpc_req_if import tpc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [TPC_KEY_W-1:0] request_key;

  modport source (output valid, output request_key, input ready);
  modport sink   (input valid, input request_key, output ready);
endinterface

interface tpc_rsp_if import tpc_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [TPC_KEY_W-1:0]   entry_key;
  logic [TPC_COUNT_W-1:0] entry_count;
  logic                   was_hit;
  logic                   last_entry;

  modport source (output valid, output entry_key, output entry_count,
                  output was_hit, output last_entry, input ready);
  modport sink   (input valid, input entry_key, input entry_count,
                  input was_hit, input last_entry, output ready);
endinterface

FILE: src/threshold_promote_cache_list_top.sv
// Threshold promotion cache list. Each request key is looked up in an ordered list of up to
// volume_limit entries held in one synchronous memory (slot 0 is the head). A hit bumps the
// saturating count and moves the entry to the head once the count exceeds promote_threshold;
// a miss inserts the key at the head with count 1 and drops the tail if the list overflows.
// After every request the whole list is sent out head to tail, one transfer per entry, with
// last_entry on the tail and was_hit on all of them. One request is handled at a time: it
// is accepted, slots are scanned up to the matching slot (all slots on a miss), each moved
// entry is read and then written a slot toward the tail, the head is written, and then the
// entries are sent out; the single read port of the list memory sets this pace. Memory
// contents need no initialization: only slots below the fill count are read.
module threshold_promote_cache_list_top import tpc_pkg::*; #(
  parameter int MAX_ENTRIES = TPC_MAX_ENTRIES,
  parameter int KEY_BITS    = TPC_KEY_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [TPC_CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [TPC_CFG_DATA_W-1:0] cfg_data_i,
  tpc_req_if.sink                   req_i,
  tpc_rsp_if.source                 rsp_o
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int OW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = ((OW > TPC_VOL_W) ? OW : TPC_VOL_W) + 1;
  localparam int EW = KEY_BITS + TPC_COUNT_W;

  tpc_state_e state_q, state_d;

  logic [TPC_COUNT_W-1:0] thr_q;
  logic [TPC_VOL_W-1:0]   vol_q;

  logic [KEY_BITS-1:0]    key_q, key_d;
  logic [TPC_COUNT_W-1:0] cnt_q, cnt_d;
  logic                   hit_q, hit_d;
  logic [IW-1:0]          head_addr_q, head_addr_d;
  logic [IW-1:0]          sh_idx_q, sh_idx_d;
  logic [IW-1:0]          idx_q, idx_d;
  logic [OW-1:0]          occ_q, occ_d;

  logic [EW-1:0] mem [MAX_ENTRIES];
  logic [EW-1:0] rd_data_q;
  logic          mem_re, mem_we;
  logic [IW-1:0] mem_raddr, mem_waddr;
  logic [EW-1:0] mem_wdata;

  logic [KEY_BITS-1:0]    rd_key;
  logic [TPC_COUNT_W-1:0] rd_cnt;
  logic [TPC_COUNT_W-1:0] cnt_inc;
  logic [CW-1:0]          occ_w, lim_w, idx_next_w, occ_base, occ_new;
  logic [IW-1:0]          miss_shift;
  logic                   match, at_tail, promote, hit_case;

  assign rd_key  = rd_data_q[EW-1:TPC_COUNT_W];
  assign rd_cnt  = rd_data_q[TPC_COUNT_W-1:0];
  assign cnt_inc = (rd_cnt == TPC_COUNT_MAX) ? rd_cnt : rd_cnt + TPC_COUNT_ONE;

  assign occ_w      = CW'(occ_q);
  assign idx_next_w = CW'(idx_q) + CW'(1);
  assign lim_w      = (vol_q == '0) ? CW'(1) :
                      ((CW'(vol_q) > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(vol_q));

  assign match   = (rd_key == key_q);
  assign at_tail = (idx_next_w == occ_w);
  assign promote = (cnt_inc > thr_q) && (idx_q != '0);

  // A full list drops its tail on a miss, so that slot is never moved
  assign miss_shift = (occ_w == CW'(MAX_ENTRIES)) ? IW'(MAX_ENTRIES - 1) : occ_q[IW-1:0];

  assign hit_case = (state_q == ST_SEARCH) && match;
  assign occ_base = hit_case ? occ_w : occ_w + CW'(1);
  assign occ_new  = (occ_base > lim_w) ? occ_base - CW'(1) : occ_base;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= TPC_THR_RESET;
      vol_q <= TPC_VOL_RESET;
    end else if (cfg_we_i) begin
      case (tpc_cfg_reg_e'(cfg_idx_i))
        REG_THRESHOLD: thr_q <= cfg_data_i;
        REG_VOLUME:    vol_q <= cfg_data_i[TPC_VOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          state_d = (occ_q == '0) ? ST_HEAD : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (match) begin
          state_d = promote ? ST_SH_RD : ST_HEAD;
        end else if (at_tail) begin
          state_d = (miss_shift != '0) ? ST_SH_RD : ST_HEAD;
        end
      end
      ST_SH_RD:   state_d = ST_SH_WR;
      ST_SH_WR:   state_d = (sh_idx_q == IW'(1)) ? ST_HEAD : ST_SH_RD;
      ST_HEAD:    state_d = ST_EMIT_RD;
      ST_EMIT_RD: state_d = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (rsp_o.ready && at_tail) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake and memory control
  always_comb begin
    req_i.ready = 1'b0;
    rsp_o.valid = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = idx_q;
    mem_we      = 1'b0;
    mem_waddr   = head_addr_q;
    mem_wdata   = {key_q, cnt_q};
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        mem_re      = req_i.valid && (occ_q != '0);
        mem_raddr   = '0;
      end
      ST_SEARCH: begin
        mem_re    = !match && !at_tail;
        mem_raddr = idx_q + IW'(1);
      end
      ST_SH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = sh_idx_q - IW'(1);
      end
      ST_SH_WR: begin
        // move one entry a slot toward the tail
        mem_we    = 1'b1;
        mem_waddr = sh_idx_q;
        mem_wdata = rd_data_q;
      end
      ST_HEAD: begin
        mem_we = 1'b1;
      end
      ST_EMIT_RD: begin
        mem_re = 1'b1;
      end
      ST_EMIT_OUT: begin
        rsp_o.valid = 1'b1;
        // prefetch the next entry as this one transfers
        mem_re      = rsp_o.ready && !at_tail;
        mem_raddr   = idx_q + IW'(1);
      end
      default: ;
    endcase
  end

  assign rsp_o.entry_key   = TPC_KEY_W'(rd_key);
  assign rsp_o.entry_count = rd_cnt;
  assign rsp_o.was_hit     = hit_q;
  assign rsp_o.last_entry  = at_tail;

  // Datapath
  always_comb begin
    key_d       = key_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    head_addr_d = head_addr_q;
    sh_idx_d    = sh_idx_q;
    idx_d       = idx_q;
    occ_d       = occ_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          key_d = KEY_BITS'(req_i.request_key);
          idx_d = '0;
          if (occ_q == '0) begin
            cnt_d       = TPC_COUNT_ONE;
            hit_d       = 1'b0;
            head_addr_d = '0;
            sh_idx_d    = '0;
            occ_d       = occ_new[OW-1:0];
          end
        end
      end
      ST_SEARCH: begin
        if (match) begin
          cnt_d       = cnt_inc;
          hit_d       = 1'b1;
          head_addr_d = promote ? '0 : idx_q;
          sh_idx_d    = promote ? idx_q : '0;
          occ_d       = occ_new[OW-1:0];
        end else if (at_tail) begin
          cnt_d       = TPC_COUNT_ONE;
          hit_d       = 1'b0;
          head_addr_d = '0;
          sh_idx_d    = miss_shift;
          occ_d       = occ_new[OW-1:0];
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_SH_WR: sh_idx_d = sh_idx_q - IW'(1);
      ST_HEAD:  idx_d = '0;
      ST_EMIT_OUT: begin
        if (rsp_o.ready && !at_tail) begin
          idx_d = idx_q + IW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      occ_q   <= '0;
      hit_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      hit_q   <= hit_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    cnt_q       <= cnt_d;
    head_addr_q <= head_addr_d;
    sh_idx_q    <= sh_idx_d;
  end

  // List memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

endmodule

FILE: src/tpc_checker.sv
`include "assert_macros.svh"

module tpc_checker import tpc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   req_valid_i,
  input logic                   req_ready_i,
  input logic                   rsp_valid_i,
  input logic                   rsp_ready_i,
  input logic [TPC_KEY_W-1:0]   rsp_key_i,
  input logic [TPC_COUNT_W-1:0] rsp_count_i,
  input logic                   rsp_last_i
);

  // hold a stalled result
  `TPC_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_key_i) && $stable(rsp_count_i), "stalled result changed")

  `TPC_ASSERT(a_req_one_at_a_time, req_valid_i && req_ready_i |=> !req_ready_i, "request taken while busy")

  `TPC_NEVER(a_no_overlap, req_ready_i && rsp_valid_i, "request ready while list is sent")

  `TPC_ASSERT(a_last_ends_run, rsp_valid_i && rsp_ready_i && rsp_last_i |=> !rsp_valid_i, "result after tail entry")

  `TPC_NEVER(a_count_nonzero, rsp_valid_i && (rsp_count_i == '0), "zero entry count")

endmodule

bind threshold_promote_cache_list_top tpc_checker u_tpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_key_i   (rsp_o.entry_key),
  .rsp_count_i (rsp_o.entry_count),
  .rsp_last_i  (rsp_o.last_entry)
);

FILE: sim/threshold_promote_cache_list_top_tb.sv
`timescale 1ns / 100ps

module threshold_promote_cache_list_top_tb;
  import tpc_pkg::*;

  localparam int SLOTS        = TPC_MAX_ENTRIES;
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 60;
  localparam int MAX_PRINTS   = 40;

  typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e                 kind;
    tpc_cfg_reg_e              sel;
    logic [TPC_CFG_DATA_W-1:0] data;
    logic [TPC_KEY_W-1:0]      key;
    logic                      typed;
    logic [TPC_COUNT_W-1:0]    exp_count;
    logic                      exp_hit;
  } row_t;

  typedef struct {
    logic [TPC_KEY_W-1:0]   key;
    logic [TPC_COUNT_W-1:0] count;
    logic                   hit;
    logic                   last;
  } listing_t;

  // Typed rows hold a single-entry list whose key is the request key.
  localparam int NUM_ROWS = 30;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h0000_0000, 1'b1, 16'd1, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'hFFFF_FFFF, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h0000_0000, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h0000_0000, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h0000_0000, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'hA5A5_5A5A, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h1234_5678, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h8000_0001, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'hFFFF_FFFF, 1'b0, 16'd0, 1'b0},
    '{ROW_WRITE,   REG_THRESHOLD, 16'h0000, 32'h0000_0000, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h8000_0001, 1'b0, 16'd0, 1'b0},
    // shrink one entry per request after the limit drops below the fill
    '{ROW_WRITE,   REG_VOLUME,    16'h0001, 32'h0000_0000, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h8000_0001, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h8000_0001, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h8000_0001, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h5555_5555, 1'b1, 16'd1, 1'b0},
    // zero limit acts as one; upper data bits are dropped
    '{ROW_WRITE,   REG_VOLUME,    16'hFFF0, 32'h0000_0000, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h5555_5555, 1'b1, 16'd2, 1'b1},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'hAAAA_AAAA, 1'b1, 16'd1, 1'b0},
    // limit above the slot count saturates; top threshold never promotes
    '{ROW_WRITE,   REG_THRESHOLD, 16'hFFFF, 32'h0000_0000, 1'b0, 16'd0, 1'b0},
    '{ROW_WRITE,   REG_VOLUME,    16'h000F, 32'h0000_0000, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h0000_0001, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h0000_0002, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h0000_0004, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h0000_0008, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h0000_0010, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h0000_0020, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h0000_0040, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h0000_0080, 1'b0, 16'd0, 1'b0},
    '{ROW_REQUEST, REG_THRESHOLD, 16'h0000, 32'h0000_0001, 1'b0, 16'd0, 1'b0}
  };

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [TPC_CFG_IDX_W-1:0]  cfg_idx_i;
  logic [TPC_CFG_DATA_W-1:0] cfg_data_i;

  tpc_req_if req_if ();
  tpc_rsp_if rsp_if ();

  // list model, slot 0 is the head
  logic [TPC_KEY_W-1:0]   list_key   [SLOTS+1];
  logic [TPC_COUNT_W-1:0] list_count [SLOTS+1];
  int                     fill;
  logic [TPC_COUNT_W-1:0] promo_thr;
  logic [TPC_VOL_W-1:0]   vol_q;

  listing_t pending_entries [$];
  int       mismatch_count;
  int       stall_mode;
  logic [4:0] stall_phase = '0;

  threshold_promote_cache_list_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int effective_volume();
    if (vol_q == '0) return 1;
    if (vol_q > SLOTS) return SLOTS;
    return int'(vol_q);
  endfunction

  function automatic void insert_head(input int pos, input logic [TPC_KEY_W-1:0] key,
                                      input logic [TPC_COUNT_W-1:0] cnt);
    for (int i = pos; i > 0; i--) begin
      list_key[i]   = list_key[i-1];
      list_count[i] = list_count[i-1];
    end
    list_key[0]   = key;
    list_count[0] = cnt;
  endfunction

  // Apply one request to the list and queue the listing it produces.
  function automatic void update_list(input logic [TPC_KEY_W-1:0] key, input bit listed);
    int                     pos;
    bit                     hit;
    logic [TPC_COUNT_W-1:0] cnt;
    listing_t               item;
    hit = 1'b0;
    pos = fill;
    for (int i = 0; i < fill; i++)
      if (!hit && list_key[i] == key) begin
        hit = 1'b1;
        pos = i;
      end
    if (hit) begin
      cnt = list_count[pos];
      if (cnt != TPC_COUNT_MAX) cnt++;
      list_count[pos] = cnt;
      if (cnt > promo_thr && pos != 0) insert_head(pos, key, cnt);
    end else begin
      insert_head(fill, key, TPC_COUNT_ONE);
      fill++;
    end
    // at most one tail entry leaves per request
    if (fill > effective_volume()) fill--;
    if (listed)
      for (int i = 0; i < fill; i++) begin
        item.key   = list_key[i];
        item.count = list_count[i];
        item.hit   = hit;
        item.last  = (i == fill - 1);
        pending_entries.push_back(item);
      end
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic send_request(input logic [TPC_KEY_W-1:0] key, input bit listed);
    req_if.valid       <= 1'b1;
    req_if.request_key <= key;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    update_list(key, listed);
  endtask

  task automatic pause_sender(input int gap_max);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and hold until every queued entry has been seen.
  task automatic hold_and_drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_entries.size() != 0);
  endtask

  task automatic write_reg(input tpc_cfg_reg_e sel, input logic [TPC_CFG_DATA_W-1:0] data);
    hold_and_drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == REG_THRESHOLD) promo_thr = data[TPC_COUNT_W-1:0];
    else vol_q = data[TPC_VOL_W-1:0];
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 5'd1;
    case (stall_mode)
      0: rsp_if.ready <= 1'b1;
      1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
      2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
      default: rsp_if.ready <= (stall_phase >= 5'd9);
    endcase
  end

  always @(posedge clk_i) begin
    listing_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_entries.size() == 0) begin
        note_mismatch($sformatf("entry %h with nothing pending", rsp_if.entry_key));
      end else begin
        want = pending_entries.pop_front();
        if (rsp_if.entry_key !== want.key)
          note_mismatch($sformatf("entry_key %h, want %h", rsp_if.entry_key, want.key));
        if (rsp_if.entry_count !== want.count)
          note_mismatch($sformatf("entry_count %0d, want %0d (key %h)",
                                  rsp_if.entry_count, want.count, want.key));
        if (rsp_if.was_hit !== want.hit)
          note_mismatch($sformatf("was_hit %b, want %b (key %h)",
                                  rsp_if.was_hit, want.hit, want.key));
        if (rsp_if.last_entry !== want.last)
          note_mismatch($sformatf("last_entry %b, want %b (key %h)",
                                  rsp_if.last_entry, want.last, want.key));
      end
    end
  end

  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int                        burst;
    int                        gap_max;
    int                        pool_size;
    int                        sent;
    logic [TPC_KEY_W-1:0]      key_pool [12];
    logic [TPC_KEY_W-1:0]      key;
    logic [TPC_CFG_DATA_W-1:0] word;
    listing_t                  typed_entry;

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_THRESHOLD;
    cfg_data_i         = '0;
    req_if.valid       = 1'b0;
    req_if.request_key = '0;
    stall_mode         = 1;
    mismatch_count     = 0;
    fill               = 0;
    promo_thr          = TPC_THR_RESET;
    vol_q              = TPC_VOL_RESET;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_WRITE) begin
        write_reg(DIRECTED[r].sel, DIRECTED[r].data);
      end else begin
        if (DIRECTED[r].typed) begin
          typed_entry.key   = DIRECTED[r].key;
          typed_entry.count = DIRECTED[r].exp_count;
          typed_entry.hit   = DIRECTED[r].exp_hit;
          typed_entry.last  = 1'b1;
          pending_entries.push_back(typed_entry);
        end
        send_request(DIRECTED[r].key, !DIRECTED[r].typed);
        pause_sender(2);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      word      = 16'($urandom_range(0, 65535));
      word[3:0] = (ph == 0) ? 4'd8 : 4'($urandom_range(0, 15));
      write_reg(REG_VOLUME, word);
      case ($urandom_range(0, 5))
        0: word = 16'h0000;
        1: word = 16'hFFFF;
        2: word = 16'hFFFE;
        5: word = 16'($urandom_range(0, 65535));
        default: word = 16'($urandom_range(1, 6));
      endcase
      write_reg(REG_THRESHOLD, word);

      // a pool a little larger than the list keeps hits and evictions frequent
      pool_size = effective_volume() + $urandom_range(0, 4);
      for (int k = 0; k < pool_size; k++)
        case ($urandom_range(0, 7))
          0: key_pool[k] = '0;
          1: key_pool[k] = '1;
          default: key_pool[k] = $urandom;
        endcase
      stall_mode = (ph == 2) ? 0 : $urandom_range(0, 3);
      gap_max    = (ph == 2) ? 0 : $urandom_range(1, 6);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 10);
        for (int b = 0; b < burst; b++) begin
          key = ($urandom_range(0, 9) == 0) ? $urandom
                                            : key_pool[$urandom_range(0, pool_size - 1)];
          send_request(key, 1'b1);
          sent++;
        end
        if (ph == 3 || $urandom_range(0, 15) == 0) hold_and_drain();
        else pause_sender(gap_max);
      end
    end

    hold_and_drain();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
